// ===== design/bounded_integer_set_assert.svh =====
// Assertion macros for the bounded integer set top level.
`ifndef BOUNDED_INTEGER_SET_ASSERT_SVH
`define BOUNDED_INTEGER_SET_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BIS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define BIS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/bis_pkg.sv =====
// Package with the types and constants of the bounded integer set.
package bis_pkg;

    localparam int CAPACITY   = 16;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int COUNT_W    = 5;
    localparam int WORD_W     = 32;
    localparam int CFG_ADDR_W = 3;

    typedef logic signed [WORD_W-1:0] t_word;

    localparam t_word MIN_SEED = {1'b0, {(WORD_W-1){1'b1}}};
    localparam t_word MAX_SEED = {1'b1, {(WORD_W-1){1'b0}}};

    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_DEL = 1'b1;

    // Register index, taken from the word address bit of paddr.
    localparam logic CFG_IDX_LOW  = 1'b0;
    localparam logic CFG_IDX_HIGH = 1'b1;

    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_PRESENT = 3'd1,
        ST_REMOVED = 3'd2,
        ST_ABSENT  = 3'd3,
        ST_RANGE   = 3'd4,
        ST_FULL    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic  req_type;
        t_word value;
    } t_in_word;

    typedef struct packed {
        t_status            status;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
        t_word              min_value;
        t_word              max_value;
    } t_out_word;

    typedef struct packed {
        logic add_en;
        logic del_en;
    } t_cell_ctl;

endpackage

// ===== design/bis_cell.sv =====
// One storage cell of the set row: member slot, key match and min/max scan stage.
module bis_cell import bis_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_word     i_key,
    input  t_cell_ctl i_ctl,
    input  logic      i_prev_valid,
    input  logic      i_prev_seen,
    input  t_word     i_next_value,
    input  logic      i_next_valid,
    input  t_word     i_min,
    input  t_word     i_max,
    output t_word     o_value,
    output logic      o_valid,
    output logic      o_seen,
    output t_word     o_min,
    output t_word     o_max
);

    t_word r_value;
    t_word n_value;
    logic  r_valid;
    logic  n_valid;
    t_word r_min;
    t_word n_min;
    t_word r_max;
    t_word n_max;
    logic  hit;
    logic  load;
    logic  shift;

    // A hit here or in any earlier cell marks this cell for the delete shift.
    assign hit    = r_valid && (r_value == i_key);
    assign o_seen = i_prev_seen | hit;
    // The first empty cell takes a new member.
    assign load   = i_ctl.add_en && !r_valid && i_prev_valid;
    assign shift  = i_ctl.del_en && o_seen;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (shift) begin
            n_value = i_next_value;
            n_valid = i_next_valid;
        end else if (load) begin
            n_value = i_key;
            n_valid = 1'b1;
        end
    end

    always_comb begin
        n_min = i_min;
        n_max = i_max;
        if (r_valid && (r_value < i_min)) begin
            n_min = r_value;
        end
        if (r_valid && (r_value > i_max)) begin
            n_max = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_min   <= n_min;
        r_max   <= n_max;
    end

    assign o_value = r_value;
    assign o_valid = r_valid;
    assign o_min   = r_min;
    assign o_max   = r_max;

endmodule

// ===== design/bis_cfg.sv =====
// Range registers of the bounded integer set behind an APB-style port.
module bis_cfg import bis_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0]     pwdata,
    output logic [WORD_W-1:0]     prdata,
    output logic                  pready,
    output t_word                 o_range_low,
    output t_word                 o_range_high
);

    t_word r_range_low;
    t_word n_range_low;
    t_word r_range_high;
    t_word n_range_high;
    logic  wr_en;
    logic  idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[CFG_ADDR_W-1];

    always_comb begin
        n_range_low  = r_range_low;
        n_range_high = r_range_high;
        if (wr_en) begin
            unique case (idx)
                CFG_IDX_LOW:  n_range_low  = t_word'(pwdata);
                CFG_IDX_HIGH: n_range_high = t_word'(pwdata);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            CFG_IDX_LOW:  prdata = r_range_low;
            CFG_IDX_HIGH: prdata = r_range_high;
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low  <= '0;
            r_range_high <= '0;
        end else begin
            r_range_low  <= n_range_low;
            r_range_high <= n_range_high;
        end
    end

    assign o_range_low  = r_range_low;
    assign o_range_high = r_range_high;

endmodule

// ===== design/bounded_integer_set.sv =====
// Top level of the bounded integer set: cell row, request sequencer and output register.
// Usage: a request word (req_type, value) enters on the input channel when
// i_in_valid and o_in_ready are both high. req_type REQ_ADD inserts the value,
// REQ_DEL removes it; values outside [range_low, range_high] are refused.
// Each request yields exactly one result word (status, count, is_empty,
// min_value, max_value) on the output channel, taken when o_out_valid and
// i_out_ready are both high. The range registers sit behind the APB-style
// port. They are to be written only while the block is idle; the user must
// ensure this, as the block itself does not enforce it. After acceptance the
// sequencer runs an update state, then a scan state in which the running
// minimum and maximum walk down the row of cells, then an emit state that
// loads the output register. The sequencer takes no new request before the
// previous one has reached the output register; it accepts only in idle.
// A new request is accepted while a previous result still waits in the
// output register; if the receiver stalls, the next result waits in the
// sequencer until the output register is free.
// Reset empties the set, clears both range registers to zero and leaves
// the output channel with no word pending.
module bounded_integer_set import bis_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_word,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0]     pwdata,
    output logic [WORD_W-1:0]     prdata,
    output logic                  pready
);

`include "bounded_integer_set_assert.svh"

    // Configuration registers.
    t_word range_low;
    t_word range_high;

    bis_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_range_low  (range_low),
        .o_range_high (range_high)
    );

    // Sequencer state and the request held during its processing.
    t_state             r_state;
    t_state             n_state;
    logic               r_req;
    t_word              r_key;
    t_status            r_status;
    t_status            n_status;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [CNT_W-1:0]   r_scan_cnt;
    logic [CNT_W-1:0]   n_scan_cnt;
    logic               r_out_valid;
    t_out_word          r_out_word;

    logic               accept;
    logic               in_update;
    logic               scan_last;
    logic               out_load;
    logic               in_range;
    logic               hit_any;
    logic               full;
    t_cell_ctl          cell_ctl;
    t_out_word          result;

    // Cell row wiring: apart from the shared key and control, each cell sees its neighbors only.
    t_word              row_value [CAPACITY];
    logic [CAPACITY-1:0] row_valid;
    logic [CAPACITY-1:0] row_seen;
    t_word              row_min   [CAPACITY];
    t_word              row_max   [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic  prev_valid;
        logic  prev_seen;
        t_word prev_min;
        t_word prev_max;
        t_word next_value;
        logic  next_valid;

        // The head of the row starts the scan from neutral extremes and sits
        // behind an always-occupied position; the tail pulls in an empty slot.
        if (g == 0) begin : g_head
            assign prev_valid = 1'b1;
            assign prev_seen  = 1'b0;
            assign prev_min   = MIN_SEED;
            assign prev_max   = MAX_SEED;
        end else begin : g_body
            assign prev_valid = row_valid[g-1];
            assign prev_seen  = row_seen[g-1];
            assign prev_min   = row_min[g-1];
            assign prev_max   = row_max[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign next_value = '0;
            assign next_valid = 1'b0;
        end else begin : g_inner
            assign next_value = row_value[g+1];
            assign next_valid = row_valid[g+1];
        end

        bis_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_key        (r_key),
            .i_ctl        (cell_ctl),
            .i_prev_valid (prev_valid),
            .i_prev_seen  (prev_seen),
            .i_next_value (next_value),
            .i_next_valid (next_valid),
            .i_min        (prev_min),
            .i_max        (prev_max),
            .o_value      (row_value[g]),
            .o_valid      (row_valid[g]),
            .o_seen       (row_seen[g]),
            .o_min        (row_min[g]),
            .o_max        (row_max[g])
        );
    end

    // The last cell's seen flag tells whether any stored member matches.
    assign hit_any  = row_seen[CAPACITY-1];
    assign full     = (r_count == CNT_W'(CAPACITY));
    assign in_range = !(r_key < range_low) && !(r_key > range_high);

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (accept)    n_state = S_UPDATE;
            S_UPDATE:                n_state = S_SCAN;
            S_SCAN:   if (scan_last) n_state = S_EMIT;
            S_EMIT:   if (out_load)  n_state = S_IDLE;
            default:                 n_state = S_IDLE;
        endcase
    end

    // Output decode of the sequencer.
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        in_update  = (r_state == S_UPDATE);
        scan_last  = (r_state == S_SCAN) && (r_scan_cnt == CNT_W'(CAPACITY - 1));
        out_load   = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
    end

    assign accept = i_in_valid && o_in_ready;

    // The set update happens only in the update state.
    always_comb begin
        cell_ctl.add_en = in_update && in_range && (r_req == REQ_ADD) && !hit_any && !full;
        cell_ctl.del_en = in_update && in_range && (r_req == REQ_DEL);
    end

    always_comb begin
        n_status = r_status;
        n_count  = r_count;
        if (in_update) begin
            if (!in_range) begin
                n_status = ST_RANGE;
            end else if (r_req == REQ_ADD) begin
                if (hit_any) begin
                    n_status = ST_PRESENT;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_ADDED;
                    n_count  = r_count + CNT_W'(1);
                end
            end else begin
                if (hit_any) begin
                    n_status = ST_REMOVED;
                    n_count  = r_count - CNT_W'(1);
                end else begin
                    n_status = ST_ABSENT;
                end
            end
        end
    end

    always_comb begin
        n_scan_cnt = '0;
        if (r_state == S_SCAN) begin
            n_scan_cnt = r_scan_cnt + CNT_W'(1);
        end
    end

    // An empty set reports range_low for both extremes.
    always_comb begin
        result.status    = r_status;
        result.count     = COUNT_W'(r_count);
        result.is_empty  = (r_count == '0);
        result.min_value = result.is_empty ? range_low : row_min[CAPACITY-1];
        result.max_value = result.is_empty ? range_low : row_max[CAPACITY-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_scan_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_scan_cnt <= n_scan_cnt;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_in_word.req_type;
            r_key <= i_in_word.value;
        end
        r_status <= n_status;
        if (out_load) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // The member count never exceeds the number of cells.
    `BIS_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(CAPACITY), "member count above capacity")
    // Outside the update state, the occupied cells agree with the member count.
    `BIS_ASSERT_NOW(a_row_count, r_state != S_UPDATE, $countones(row_valid) == r_count,
        "occupied cells disagree with member count")
    // An add grows the set by exactly one member.
    `BIS_ASSERT_NEXT(a_add_grows, cell_ctl.add_en, r_count == $past(r_count) + CNT_W'(1),
        "add did not grow the set by one")
    // An accepted request always goes straight to the update cycle.
    `BIS_ASSERT_NEXT(a_accept_update, accept, r_state == S_UPDATE,
        "accepted request skipped the update cycle")

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the bounded integer set: range registers, add/delete words, results.
`timescale 1ns / 1ps

module tb_top;
    import bis_pkg::*;

    // Widest signed values a word can carry.
    localparam longint WORD_MIN = -64'sd2147483648;
    localparam longint WORD_MAX = 64'sd2147483647;

    // Runaway guard. The slowest legal run is roughly 1000 words, each paying the
    // full request interval plus a full sender gap and a full receiver stall.
    // The limit leaves a wide margin on top of that.
    localparam int unsigned CYCLE_LIMIT = 400_000;

    // Cycles allowed after the last result for any stray word to show up. This
    // covers the update, the walk through the cell row and the output register.
    localparam int unsigned TAIL_CYCLES = 2 * CAPACITY + 8;

    // Stop printing mismatch lines after this many, but keep counting them.
    localparam int unsigned PRINT_CAP = 200;

    // The scoreboard keeps a shadow copy of the set and the range registers.
    // Every accepted request word is applied to the shadow, and the resulting
    // expected result word is queued. Result words are compared in order.
    class set_tracker;
        t_word       range_lo;
        t_word       range_hi;
        t_word       shadow_members[CAPACITY];
        int unsigned shadow_count;
        t_out_word   pending_results[$];
        int unsigned errors;

        function new();
            range_lo     = '0;
            range_hi     = '0;
            shadow_count = 0;
            errors       = 0;
        endfunction

        function void set_bound(logic idx, t_word v);
            if (idx == CFG_IDX_LOW) begin
                range_lo = v;
            end else begin
                range_hi = v;
            end
        endfunction

        task report(string what);
            if (errors < PRINT_CAP) begin
                $display("[tb] mismatch at %0t: %s", $realtime, what);
            end
            errors++;
        endtask

        // Apply one accepted request to the shadow set and queue the result it causes.
        function void note_request(t_in_word w);
            t_out_word want;
            t_word     x;
            t_status   st;
            int        hit;
            x   = w.value;
            hit = -1;
            // The range test comes first, for adds and deletes alike. An empty
            // range (low above high) fails every value here.
            if (x < range_lo || x > range_hi) begin
                st = ST_RANGE;
            end else begin
                for (int i = 0; i < shadow_count; i++) begin
                    if (hit < 0 && shadow_members[i] == x) begin
                        hit = i;
                    end
                end
                if (w.req_type == REQ_ADD) begin
                    // A value already present wins over a full set.
                    if (hit >= 0) begin
                        st = ST_PRESENT;
                    end else if (shadow_count >= CAPACITY) begin
                        st = ST_FULL;
                    end else begin
                        shadow_members[shadow_count] = x;
                        shadow_count++;
                        st = ST_ADDED;
                    end
                end else if (hit >= 0) begin
                    // The last entry fills the freed slot.
                    shadow_members[hit] = shadow_members[shadow_count - 1];
                    shadow_count--;
                    st = ST_REMOVED;
                end else begin
                    st = ST_ABSENT;
                end
            end

            want.status    = st;
            want.count     = shadow_count[COUNT_W-1:0];
            want.is_empty  = (shadow_count == 0);
            want.min_value = range_lo;
            want.max_value = range_lo;
            // Extremes come from the stored members only, even those that a later
            // range change has left outside the range.
            if (shadow_count != 0) begin
                want.min_value = shadow_members[0];
                want.max_value = shadow_members[0];
                for (int i = 1; i < shadow_count; i++) begin
                    if (shadow_members[i] < want.min_value) begin
                        want.min_value = shadow_members[i];
                    end
                    if (shadow_members[i] > want.max_value) begin
                        want.max_value = shadow_members[i];
                    end
                end
            end
            pending_results.push_back(want);
        endfunction

        task check_result(t_out_word got);
            t_out_word want;
            if (pending_results.size() == 0) begin
                report("result word with no request outstanding");
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    report($sformatf(
                        "status %0d/%0d count %0d/%0d empty %0d/%0d min %0d/%0d max %0d/%0d",
                        got.status, want.status, got.count, want.count,
                        got.is_empty, want.is_empty, got.min_value, want.min_value,
                        got.max_value, want.max_value));
                end
            end
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_word              i_in_word;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_word             o_out_word;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [WORD_W-1:0]     pwdata;
    logic [WORD_W-1:0]     prdata;
    logic                  pready;

    set_tracker  sb = new();
    int unsigned rx_stall = 0;
    int unsigned cycle_count = 0;
    // Set for the last part of the run, where neither side idles.
    bit          quiet = 1'b0;

    bounded_integer_set dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: checks every result word taken at a clock edge, then decides
    // whether the next cycles are a stall burst. Values read right after the
    // edge are the ones the block saw at that edge.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            sb.check_result(o_out_word);
        end
        if (rx_stall == 0 && !quiet && $urandom_range(0, 9) == 0) begin
            rx_stall = $urandom_range(1, 17);
        end
        if (rx_stall != 0) begin
            rx_stall--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Timeout: a missing result word or a hung handshake ends here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[bounded_integer_set] ERROR");
        $finish;
    end

    // Offer one request word and hold it until the block takes it. Afterwards
    // the sender may go quiet for a random burst. If no burst follows, valid
    // stays high so that the next word can follow back to back.
    task send_item(t_in_word w);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.note_request(w);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    task send_req(logic kind, t_word v);
        t_in_word w;
        w.req_type = kind;
        w.value    = v;
        send_item(w);
    endtask

    // Stop sending and wait until every outstanding result word has been taken.
    // Each request causes exactly one result, so the block is idle after this.
    task wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    // One APB write followed by a read back of the same register. psel stays
    // high at the end so that a second access can follow in the next cycle.
    task cfg_write(logic idx, t_word data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.set_bound(idx, data);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== data) begin
            sb.report($sformatf("register %0d read %h, written %h", idx, prdata, data));
        end
    endtask

    // Range registers change only with the block idle.
    task set_range(longint lo, longint hi);
        wait_drained();
        cfg_write(CFG_IDX_LOW, t_word'(lo));
        cfg_write(CFG_IDX_HIGH, t_word'(hi));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Values are drawn mostly from a small window inside the range, so that
    // adds and deletes hit each other and the set fills and drains. The rest
    // are stored members, the range borders and their neighbors, and full-width
    // random values.
    function automatic t_word pick_value(longint lo, longint hi);
        longint      span;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return t_word'($urandom);
        end
        if (r < 22 && sb.shadow_count != 0) begin
            return sb.shadow_members[$urandom_range(0, sb.shadow_count - 1)];
        end
        if (r < 30) begin
            case ($urandom_range(0, 3))
                0:       return t_word'(lo);
                1:       return t_word'(hi);
                2:       return t_word'(lo - 1);
                default: return t_word'(hi + 1);
            endcase
        end
        if (lo > hi) begin
            return t_word'(hi + longint'($urandom_range(0, 31)) - 8);
        end
        span = hi - lo;
        if (span > 23) begin
            span = 23;
        end
        return t_word'(lo + longint'($urandom_range(0, int'(span))));
    endfunction

    // One random phase under one range setting. add_pct steers the set toward
    // filling up or draining.
    task run_phase(longint lo, longint hi, int unsigned n_items, int unsigned add_pct);
        logic kind;
        set_range(lo, hi);
        repeat (n_items) begin
            kind = ($urandom_range(0, 99) < add_pct) ? REQ_ADD : REQ_DEL;
            send_req(kind, pick_value(lo, hi));
            // Now and then the sender holds off until the block has emptied.
            if (!quiet && $urandom_range(0, 199) == 0) begin
                wait_drained();
            end
        end
    endtask

    initial begin
        longint rlo;
        longint rhi;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_word   <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset range is the single value zero: add, repeat add, a value just
        // above the range, delete, delete again.
        send_req(REQ_ADD, t_word'(0));
        send_req(REQ_ADD, t_word'(0));
        send_req(REQ_ADD, t_word'(1));
        send_req(REQ_DEL, t_word'(0));
        send_req(REQ_DEL, t_word'(0));

        // Widest range: both extreme values go in, and a delete of an absent value.
        set_range(WORD_MIN, WORD_MAX);
        send_req(REQ_ADD, t_word'(WORD_MIN));
        send_req(REQ_ADD, t_word'(WORD_MAX));
        send_req(REQ_DEL, t_word'(3));

        // Narrow the range: the extremes stay stored but can no longer be
        // deleted, and they still set the reported minimum and maximum. Then
        // fill the set to capacity, try a new value on the full set, re-add a
        // present one, and delete an early entry so the last one moves down.
        set_range(-8, 7);
        send_req(REQ_DEL, t_word'(WORD_MIN));
        for (longint v = -8; v <= 5; v++) begin
            send_req(REQ_ADD, t_word'(v));
        end
        send_req(REQ_ADD, t_word'(6));
        send_req(REQ_ADD, t_word'(-8));
        send_req(REQ_DEL, t_word'(-8));

        // Random part, through several range settings.
        run_phase(-8, 7, 150, 60);
        run_phase(-3, 12, 100, 25);
        run_phase(WORD_MIN, WORD_MIN + 20, 100, 65);
        run_phase(WORD_MAX - 20, WORD_MAX, 100, 65);
        run_phase(0, 0, 40, 50);
        // Empty range: low above high refuses everything.
        run_phase(9, -9, 40, 50);
        run_phase(WORD_MIN, WORD_MAX, 150, 55);
        rlo = longint'(t_word'($urandom));
        rhi = rlo + longint'($urandom_range(0, 30));
        if (rhi > WORD_MAX) begin
            rhi = WORD_MAX;
        end
        run_phase(rlo, rhi, 120, 60);

        // Last stretch at full rate on both sides.
        wait_drained();
        quiet = 1'b1;
        run_phase(-10, 10, 100, 50);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending_results.size() != 0) begin
            sb.report("result words still outstanding at the end");
        end
        if (sb.errors == 0) begin
            $display("[bounded_integer_set] OK");
        end else begin
            $display("[bounded_integer_set] ERROR");
        end
        $finish;
    end

endmodule
